// ===== rtl/voxel_hash_point_insert_macros.svh =====
// Assertion macros for the voxel hash point insert block.
`ifndef VOXEL_HASH_POINT_INSERT_MACROS_SVH
`define VOXEL_HASH_POINT_INSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define VHPI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VHPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/vhpi_pkg.sv =====
// Package: types, constants and helpers of the voxel hash point insert block.
package vhpi_pkg;
  localparam int MAX_POINTS_DEF = 20;
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int PROBE_DEPTH = 8;
  localparam int CELL_W = 21;
  localparam int KEY_W = 3 * CELL_W;
  localparam int COORD_W = 32;
  localparam int PT_W = 3 * COORD_W;

  localparam logic [1:0] OUT_STORED = 2'd0;
  localparam logic [1:0] OUT_CELL_FULL = 2'd1;
  localparam logic [1:0] OUT_TOO_CLOSE = 2'd2;
  localparam logic [1:0] OUT_TABLE_FULL = 2'd3;

  localparam logic CFG_INV_VOXEL = 1'b0;
  localparam logic CFG_MIN_DIST = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CELL, ST_HASH, ST_PROBE_RD, ST_PROBE_CHK,
    ST_PT_RD, ST_PT_CHK, ST_WRITE, ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic              new_cell;
    logic [11:0]       slot_index;
    logic [4:0]        cell_count;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
  } result_t;

  // saturate a signed 64-bit floor quotient to 21 bits
  function automatic logic [CELL_W-1:0] sat_cell(input logic signed [63:0] q);
    logic [CELL_W-1:0] r;
    if (q > 64'sd1048575) r = 21'h0FFFFF;
    else if (q < -64'sd1048576) r = 21'h100000;
    else r = q[CELL_W-1:0];
    return r;
  endfunction
endpackage

// ===== rtl/vhpi_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface vhpi_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vhpi_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
module vhpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/voxel_hash_point_insert.sv =====
// Top level: voxel hash map point insertion with minimum-spacing downsampling.
// Usage:
//   in  channel (sink): point_x/y/z, signed Q16.16 metres, valid/ready.
//   out channel (source): outcome, new_cell, slot_index, cell_count, cell_x/y/z.
//   cfg port: cfg_we, cfg_index (0 inv_voxel_size, 1 min_dist_sq), cfg_data.
// One item is processed at a time by a sequencer around the slot table and
// the point memory, each a synchronous RAM with registered read.
// From accept to result valid the sequencer forms the cell and hash, probes
// the slot table (up to 8 slots), compares the stored points of a matching
// cell, writes back and presents the result; it returns to idle before the
// next item is taken.
// After reset a clearing pass writes every slot's valid flag to zero; input
// ready stays low meanwhile.
// The result register holds until taken; a stalled receiver lets one more
// item be taken and processed, which then waits until the register frees.
module voxel_hash_point_insert #(
  parameter int MAX_POINTS = vhpi_pkg::MAX_POINTS_DEF,
  parameter int TABLE_ENTRIES = vhpi_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  vhpi_if.sink   in_ch,
  vhpi_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);
`include "voxel_hash_point_insert_macros.svh"
  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int PD = TABLE_ENTRIES * MAX_POINTS;
  localparam int PAW = $clog2(PD);
  localparam int SLOT_W = 1 + vhpi_pkg::KEY_W + PW;
  localparam int MAXP_W = PW;
  localparam int PRW = $clog2(vhpi_pkg::PROBE_DEPTH);

  vhpi_pkg::state_t state, state_next;

  logic [31:0] inv_voxel_size;
  logic [47:0] min_dist_sq;

  logic signed [31:0] px, py, pz;
  logic signed [63:0] prod [3];
  logic [vhpi_pkg::CELL_W-1:0] vox [3];
  logic [SW-1:0] hsh;
  logic [SW-1:0] home, slot;
  logic [PRW-1:0] probe;
  logic [PW-1:0] ptr, n;
  logic [1:0] outcome;
  logic new_cell;
  logic [SW-1:0] clr_addr;
  logic out_valid;
  vhpi_pkg::result_t out_res;
  logic [63:0] sq [3];
  // squares registered between fetch-compare steps; the compare uses them next cycle
  logic sq_ok;

  // slot RAM: {valid, key, count}
  logic s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [SLOT_W-1:0] s_wdata, s_rdata;
  logic p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [vhpi_pkg::PT_W-1:0] p_wdata, p_rdata;

  vhpi_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  vhpi_ram #(.WIDTH(vhpi_pkg::PT_W), .DEPTH(PD)) u_pts (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata));

  logic [vhpi_pkg::KEY_W-1:0] key;
  assign key = {vox[0], vox[1], vox[2]};
  logic s_valid;
  logic [vhpi_pkg::KEY_W-1:0] s_key;
  logic [PW-1:0] s_count;
  assign s_valid = s_rdata[SLOT_W-1];
  assign s_key = s_rdata[SLOT_W-2 -: vhpi_pkg::KEY_W];
  assign s_count = s_rdata[PW-1:0];

  logic [PAW-1:0] base;
  assign base = PAW'(slot * MAX_POINTS);

  // per-axis absolute difference from the fetched stored point, and the distance test on the registered squares
  logic [vhpi_pkg::PT_W-1:0] cur;
  logic signed [32:0] dif [3];
  logic [31:0] mag [3];
  logic [65:0] d2sum;
  logic close;
  assign cur = {pz, py, px};
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif[a] = $signed({p_rdata[a*32+31], p_rdata[a*32 +: 32]})
             - $signed({cur[a*32+31], cur[a*32 +: 32]});
      mag[a] = dif[a][32] ? 32'(-dif[a]) : 32'(dif[a]);
    end
    d2sum = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
    close = (d2sum[65:64] == 2'b00) && (d2sum[63:0] < 64'(min_dist_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_voxel_size <= 32'd65536;
      min_dist_sq <= 48'd214748365;
    end else if (cfg_we) begin
      if (cfg_index == vhpi_pkg::CFG_INV_VOXEL) inv_voxel_size <= cfg_data[31:0];
      else min_dist_sq <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vhpi_pkg::ST_CLEAR: if (clr_addr == SW'(TABLE_ENTRIES - 1)) state_next = vhpi_pkg::ST_IDLE;
      vhpi_pkg::ST_IDLE: if (in_ch.valid) state_next = vhpi_pkg::ST_CELL;
      vhpi_pkg::ST_CELL: state_next = vhpi_pkg::ST_HASH;
      vhpi_pkg::ST_HASH: state_next = vhpi_pkg::ST_PROBE_RD;
      vhpi_pkg::ST_PROBE_RD: state_next = vhpi_pkg::ST_PROBE_CHK;
      vhpi_pkg::ST_PROBE_CHK: begin
        if (!s_valid) state_next = vhpi_pkg::ST_WRITE;
        else if (s_key == key) begin
          if (s_count >= MAXP_W'(MAX_POINTS)) state_next = vhpi_pkg::ST_DONE;
          else state_next = vhpi_pkg::ST_PT_RD;
        end else if (probe == PRW'(vhpi_pkg::PROBE_DEPTH - 1)) state_next = vhpi_pkg::ST_DONE;
        else state_next = vhpi_pkg::ST_PROBE_RD;
      end
      vhpi_pkg::ST_PT_RD: begin
        if (sq_ok && close) state_next = vhpi_pkg::ST_DONE;
        else if (ptr == n) state_next = vhpi_pkg::ST_WRITE;
        else state_next = vhpi_pkg::ST_PT_CHK;
      end
      vhpi_pkg::ST_PT_CHK: state_next = vhpi_pkg::ST_PT_RD;
      vhpi_pkg::ST_WRITE: state_next = vhpi_pkg::ST_DONE;
      vhpi_pkg::ST_DONE: if (!out_valid) state_next = vhpi_pkg::ST_IDLE;
      default: state_next = vhpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_we = 1'b0;
    s_waddr = slot;
    s_wdata = {1'b1, key, n + PW'(1)};
    s_raddr = SW'(home + SW'(probe));
    p_we = 1'b0;
    p_waddr = PAW'(base + PAW'(n));
    p_wdata = cur;
    p_raddr = PAW'(base + PAW'(ptr));
    case (state)
      vhpi_pkg::ST_CLEAR: begin
        s_we = 1'b1;
        s_waddr = clr_addr;
        s_wdata = '0;
      end
      vhpi_pkg::ST_WRITE: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vhpi_pkg::ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      sq_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (state == vhpi_pkg::ST_CLEAR) clr_addr <= clr_addr + SW'(1);
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (state == vhpi_pkg::ST_DONE && !out_valid) out_valid <= 1'b1;
      sq_ok <= (state == vhpi_pkg::ST_PT_CHK);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      vhpi_pkg::ST_IDLE: begin
        px <= in_ch.data.point_x;
        py <= in_ch.data.point_y;
        pz <= in_ch.data.point_z;
      end
      vhpi_pkg::ST_CELL: begin
        prod[0] <= px * $signed({1'b0, inv_voxel_size});
        prod[1] <= py * $signed({1'b0, inv_voxel_size});
        prod[2] <= pz * $signed({1'b0, inv_voxel_size});
      end
      vhpi_pkg::ST_HASH: begin
        probe <= '0;
        outcome <= vhpi_pkg::OUT_TABLE_FULL;
        new_cell <= 1'b0;
        n <= '0;
        slot <= '0;
      end
      vhpi_pkg::ST_PROBE_CHK: begin
        if (!s_valid) begin
          slot <= SW'(home + SW'(probe));
          n <= '0;
          new_cell <= 1'b1;
        end else if (s_key == key) begin
          slot <= SW'(home + SW'(probe));
          n <= s_count;
          ptr <= '0;
          if (s_count >= MAXP_W'(MAX_POINTS)) outcome <= vhpi_pkg::OUT_CELL_FULL;
        end else begin
          probe <= probe + PRW'(1);
        end
      end
      // compare of previous squares, in the cycle after they were formed
      vhpi_pkg::ST_PT_RD: if (sq_ok && close) outcome <= vhpi_pkg::OUT_TOO_CLOSE;
      vhpi_pkg::ST_PT_CHK: begin
        for (int a = 0; a < 3; a++) sq[a] <= mag[a] * mag[a];
        ptr <= ptr + PW'(1);
      end
      vhpi_pkg::ST_WRITE: begin
        outcome <= vhpi_pkg::OUT_STORED;
        n <= n + PW'(1);
      end
      default: ;
    endcase
  end

  // cells and hash are combinational from registered products
  always_comb begin
    for (int a = 0; a < 3; a++)
      vox[a] = vhpi_pkg::sat_cell(prod[a] >>> 32);
  end
  always_ff @(posedge clk) begin
    if (state == vhpi_pkg::ST_HASH) home <= hsh;
  end
  // only the low SW bits of each product reach the slot index
  assign hsh = (SW'(vox[0]) * SW'(73856093)) ^ (SW'(vox[1]) * SW'(19349669))
             ^ (SW'(vox[2]) * SW'(83492791));

  // result register: frees the sequencer while the receiver stalls
  always_ff @(posedge clk) begin
    if (state == vhpi_pkg::ST_DONE && !out_valid) begin
      out_res.outcome <= outcome;
      out_res.new_cell <= new_cell;
      out_res.slot_index <= 12'(slot);
      out_res.cell_count <= (outcome == vhpi_pkg::OUT_TABLE_FULL) ? 5'd0 : 5'(n);
      out_res.cell_x <= vox[0];
      out_res.cell_y <= vox[1];
      out_res.cell_z <= vox[2];
    end
  end

  assign in_ch.ready = (state == vhpi_pkg::ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_res;

  `VHPI_ASSERT_IMP(a_no_accept_busy, clk, rst, state != vhpi_pkg::ST_IDLE, !in_ch.ready)
  `VHPI_ASSERT_IMP(a_write_bounds, clk, rst, p_we, n < MAXP_W'(MAX_POINTS))
  `VHPI_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && !out_ch.ready, out_valid)
  `VHPI_ASSERT_NEXT(a_hold_data, clk, rst, out_valid && !out_ch.ready, $stable(out_res))
endmodule
